[design/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the search transposition table
// Entry layout, request and result groups, bound codes and table sizing.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Number of hash bits that select a table entry.
    localparam int INDEX_BITS = 16;
    localparam int KEY_BITS   = 16;
    localparam int HASH_BITS  = 64;
    localparam int CFG_BITS   = 10;

    // Reset value of the largest search depth.
    localparam logic [CFG_BITS-1:0] MAX_DEPTH_RESET = 10'd64;

    // Half of the largest signed integer, less one, is the top of the band test.
    localparam logic signed [31:0] BAND_TOP = 32'sd1073741822;

    // Bound kinds of a stored score.
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    // Item kinds on the input stream.
    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_PROBE  = 1'b1;

    // One stored table entry, valid flag included.
    typedef struct packed {
        logic               valid;
        logic [KEY_BITS-1:0] key;
        logic signed [7:0]  depth;
        logic [1:0]         bound;
        logic signed [31:0] score;
        logic [7:0]         move;
    } entry_t;

    // A probe as held while the table is read.
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic signed [7:0]  depth;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
    } probe_req_t;

    // Outcome of a probe.
    typedef struct packed {
        logic               cutoff;
        logic               key_match;
        logic signed [31:0] score;
        logic [7:0]         move;
    } probe_res_t;

    // Score band outside of which bound cutoffs are refused.
    typedef struct packed {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
    } band_t;

endpackage

[design/sst_table_ram.sv]
// ----------------------------------------------------------------------------
// sst_table_ram: simple dual-port table memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sst_table_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 67
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/sst_probe_eval.sv]
// ----------------------------------------------------------------------------
// sst_probe_eval: probe decision logic
// Compares a read entry with the held probe and forms the result beat.
// ----------------------------------------------------------------------------
module sst_probe_eval (
    input  sst_pkg::entry_t     entry,
    input  sst_pkg::probe_req_t req,
    input  sst_pkg::band_t      band,
    output sst_pkg::probe_res_t res
);

    logic match;
    logic depth_ok;
    logic in_band;

    // Key check against a written entry, and the stored depth test.
    assign match    = entry.valid && (entry.key == req.key);
    assign depth_ok = entry.depth >= req.depth;
    assign in_band  = (entry.score < band.hi) && (entry.score > band.lo);

    // Cutoff rules by bound kind.
    always_comb begin
        res.cutoff    = 1'b0;
        res.score     = 32'sd0;
        res.key_match = match;
        res.move      = match ? entry.move : 8'd0;
        if (match && depth_ok) begin
            case (entry.bound)
                sst_pkg::BOUND_EXACT: begin
                    res.cutoff = 1'b1;
                    res.score  = entry.score;
                end
                sst_pkg::BOUND_UPPER: begin
                    if (entry.score <= req.alpha && in_band) begin
                        res.cutoff = 1'b1;
                        res.score  = req.alpha;
                    end
                end
                sst_pkg::BOUND_LOWER: begin
                    if (entry.score >= req.beta && in_band) begin
                        res.cutoff = 1'b1;
                        res.score  = req.beta;
                    end
                end
                default: begin
                    res.cutoff = 1'b0;
                end
            endcase
        end
    end

endmodule

[design/search_transposition_table_top.sv]
// ----------------------------------------------------------------------------
// search_transposition_table_top: direct-mapped always-replace search cache
// Stream front end, clearing pass, table memory and result register.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the table, one entry per
// cycle; no beat is accepted until it is done, while configuration writes
// are taken at once. A record beat writes its entry straight into the table
// without giving a result. A probe beat first reads its entry from the
// registered table memory, then compares it and loads the result into the
// output register once that register is free; no new beat is taken until
// the result is loaded. A result waiting on the output does not stop the
// next record beat from being taken.
module search_transposition_table_top (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: max_search_depth.
    input  logic         cfg_we,
    input  logic [9:0]   cfg_wdata,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: position_hash[63:0], search_depth[71:64],
    // score_in[103:72], bound_kind[105:104], move_in[113:106],
    // window_low[145:114], window_high[177:146], zero fill[183:178].
    input  logic [183:0] s_tdata,
    // Fields from bit 0: func[0].
    input  logic [0:0]   s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: score_out[31:0], move_out[39:32].
    output logic [39:0]  m_tdata,
    // Fields from bit 0: cutoff[0], key_match[1].
    output logic [1:0]   m_tuser
);

    localparam int IW = sst_pkg::INDEX_BITS;
    localparam int EW = $bits(sst_pkg::entry_t);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [IW-1:0]               clr_addr_reg;
    logic [sst_pkg::CFG_BITS-1:0] max_depth_reg;
    sst_pkg::band_t              band_reg;
    sst_pkg::probe_req_t         req_reg;
    sst_pkg::probe_res_t         res_reg;
    logic                        m_valid_reg;

    logic                        s_fire;
    logic                        in_func;
    logic [IW-1:0]               in_slot;
    sst_pkg::entry_t             in_entry;
    sst_pkg::probe_req_t         in_req;
    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic                        ram_re;
    logic [EW-1:0]               ram_rdata;
    sst_pkg::entry_t             rd_entry;
    sst_pkg::probe_res_t         eval_res;
    logic                        res_load;

    // Unpack the input beat.
    assign in_func        = s_tuser[0];
    assign in_slot        = s_tdata[sst_pkg::HASH_BITS-1 -: IW];
    assign in_entry.valid = 1'b1;
    assign in_entry.key   = s_tdata[sst_pkg::KEY_BITS-1:0];
    assign in_entry.depth = s_tdata[71:64];
    assign in_entry.score = s_tdata[103:72];
    assign in_entry.bound = s_tdata[105:104];
    assign in_entry.move  = s_tdata[113:106];
    assign in_req.key     = s_tdata[sst_pkg::KEY_BITS-1:0];
    assign in_req.depth   = s_tdata[71:64];
    assign in_req.alpha   = s_tdata[145:114];
    assign in_req.beta    = s_tdata[177:146];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Table write port: the clearing pass, or a record beat.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s_fire && (in_func == sst_pkg::FUNC_RECORD);
            ram_waddr = in_slot;
            ram_wdata = in_entry;
        end
    end

    // A probe beat reads its entry.
    assign ram_re = s_fire && (in_func == sst_pkg::FUNC_PROBE);

    sst_table_ram #(
        .ADDR_W (IW),
        .DATA_W (EW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (in_slot),
        .rd_data (ram_rdata)
    );

    assign rd_entry = ram_rdata;

    sst_probe_eval u_eval (
        .entry (rd_entry),
        .req   (req_reg),
        .band  (band_reg),
        .res   (eval_res)
    );

    // The result is loaded once the output register is free.
    assign res_load = (state_reg == ST_LOOKUP) && (!m_valid_reg || m_tready);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == {IW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (ram_re) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (res_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers, configuration and the score band.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            max_depth_reg <= sst_pkg::MAX_DEPTH_RESET;
            band_reg.hi   <= sst_pkg::BAND_TOP - 32'sd64;
            band_reg.lo   <= 32'sd64 - sst_pkg::BAND_TOP;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we) begin
                max_depth_reg <= cfg_wdata;
            end
            band_reg.hi <= sst_pkg::BAND_TOP - $signed({22'd0, max_depth_reg});
            band_reg.lo <= $signed({22'd0, max_depth_reg}) - sst_pkg::BAND_TOP;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Probe hold and result payload registers.
    always_ff @(posedge aclk) begin
        if (ram_re) begin
            req_reg <= in_req;
        end
        if (res_load) begin
            res_reg <= eval_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.move, res_reg.score};
    assign m_tuser  = {res_reg.key_match, res_reg.cutoff};

    // A probe beat always moves on to the comparison cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> (state_reg == ST_LOOKUP))
        else $error("probe beat did not start a lookup");

    // A record beat taken while no result is waiting does not cause a result beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (in_func == sst_pkg::FUNC_RECORD) && !m_valid_reg) |=> !m_valid_reg)
        else $error("record beat produced a result");

    // A cutoff needs a key match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[0] || m_tuser[1]))
        else $error("cutoff without key match");

    // Without a cutoff the score is zero, and without a match the move is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser[0] || (m_tdata[31:0] == 32'd0))
                      && (m_tuser[1] || (m_tdata[39:32] == 8'd0))))
        else $error("unused result field not cleared");

endmodule
